>>> design/kce_pkg.sv
// shared types and constants for the keypad calculator engine
// no dependencies; used by kce_alu and keypad_calculator_engine
package kce_pkg;

    localparam int unsigned ACC_W   = 32;
    localparam int unsigned OPND_W  = 14;
    localparam int unsigned CNT_W   = $clog2(ACC_W);

    localparam logic [OPND_W-1:0] OPND_MAX  = 14'd9999;
    localparam logic [OPND_W-1:0] LIMIT_RST = 14'd999;

    // ascii key codes
    localparam logic [7:0] KEY_0   = 8'h30;
    localparam logic [7:0] KEY_9   = 8'h39;
    localparam logic [7:0] KEY_EQ  = 8'h3D;
    localparam logic [7:0] KEY_ADD = 8'h2B;
    localparam logic [7:0] KEY_SUB = 8'h2D;
    localparam logic [7:0] KEY_MUL = 8'h2A;
    localparam logic [7:0] KEY_DIV = 8'h2F;

    // register word index
    localparam logic REG_LIMIT = 1'b0;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        STS_DIGIT      = 3'd0,
        STS_OVER       = 3'd1,
        STS_OPER       = 3'd2,
        STS_RESULT     = 3'd3,
        STS_INCOMPLETE = 3'd4,
        STS_NO_NUMBER  = 3'd5,
        STS_OTHER      = 3'd6,
        STS_IGNORED    = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_POST
    } t_state;

    typedef struct packed {
        logic              start;
        t_op               op;
        logic [ACC_W-1:0]  acc;
        logic [OPND_W-1:0] opnd;
    } t_alu_req;

    typedef struct packed {
        logic             done;
        logic [ACC_W-1:0] result;
    } t_alu_rsp;

endpackage

>>> design/kce_alu.sv
// serial arithmetic unit: bit-serial add/sub, shift-add multiply, restoring divide
// depends on kce_pkg
module kce_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kce_pkg::t_alu_req i_req,
    output kce_pkg::t_alu_rsp o_rsp
);

    logic                        r_busy;
    logic                        r_done;
    logic [kce_pkg::CNT_W-1:0]   r_cnt;
    kce_pkg::t_op                r_op;
    logic [kce_pkg::ACC_W-1:0]   r_x;
    logic [kce_pkg::OPND_W-1:0]  r_y;
    logic [kce_pkg::ACC_W-1:0]   r_p;
    logic [kce_pkg::OPND_W-1:0]  r_rem;
    logic                        r_c;
    logic                        r_neg;

    logic                        w_b;
    logic                        w_s;
    logic                        w_co;
    logic [kce_pkg::OPND_W:0]    w_rem2;
    logic [kce_pkg::OPND_W:0]    w_diff;
    logic                        w_ge;

    // one bit of the add/sub chain
    assign w_b  = r_y[0] ^ (r_op == kce_pkg::OP_SUB);
    assign w_s  = r_x[0] ^ w_b ^ r_c;
    assign w_co = (r_x[0] & w_b) | (r_x[0] & r_c) | (w_b & r_c);

    // one quotient bit of the restoring divide
    assign w_rem2 = {r_rem, r_x[kce_pkg::ACC_W-1]};
    assign w_diff = w_rem2 - {1'b0, r_y};
    assign w_ge   = (w_rem2 >= {1'b0, r_y});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == kce_pkg::CNT_W'(kce_pkg::ACC_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op  <= i_req.op;
            r_x   <= (i_req.op == kce_pkg::OP_DIV && i_req.acc[kce_pkg::ACC_W-1])
                     ? (~i_req.acc + 1'b1) : i_req.acc;
            r_y   <= i_req.opnd;
            r_p   <= '0;
            r_rem <= '0;
            r_c   <= (i_req.op == kce_pkg::OP_SUB);
            r_neg <= i_req.acc[kce_pkg::ACC_W-1];
        end else if (r_busy) begin
            case (r_op)
                kce_pkg::OP_ADD, kce_pkg::OP_SUB: begin
                    r_x <= {1'b0, r_x[kce_pkg::ACC_W-1:1]};
                    r_y <= {1'b0, r_y[kce_pkg::OPND_W-1:1]};
                    r_p <= {w_s, r_p[kce_pkg::ACC_W-1:1]};
                    r_c <= w_co;
                end
                kce_pkg::OP_MUL: begin
                    if (r_y[0]) begin
                        r_p <= r_p + r_x;
                    end
                    r_x <= {r_x[kce_pkg::ACC_W-2:0], 1'b0};
                    r_y <= {1'b0, r_y[kce_pkg::OPND_W-1:1]};
                end
                kce_pkg::OP_DIV: begin
                    r_rem <= w_ge ? w_diff[kce_pkg::OPND_W-1:0]
                                  : w_rem2[kce_pkg::OPND_W-1:0];
                    r_x   <= {r_x[kce_pkg::ACC_W-2:0], w_ge};
                end
                default: begin
                    // no pending operator: operand passes through
                end
            endcase
        end
    end

    always_comb begin
        o_rsp.done = r_done;
        case (r_op)
            kce_pkg::OP_ADD, kce_pkg::OP_SUB, kce_pkg::OP_MUL: o_rsp.result = r_p;
            kce_pkg::OP_DIV: o_rsp.result = r_neg ? (~r_x + 1'b1) : r_x;
            default: o_rsp.result = {{(kce_pkg::ACC_W-kce_pkg::OPND_W){1'b0}}, r_y};
        endcase
    end

endmodule

>>> design/keypad_calculator_engine.sv
// top level of the keypad calculator engine: key decode, operand entry, control, apb register
// depends on kce_pkg and kce_alu
//
//  channel   direction  signals                                      width
//  key       in         i_key_valid / o_key_ready, i_key_code        8
//  result    out        o_res_valid / i_res_ready, o_status, o_value 3 + 32 signed
//  config    in         psel penable pwrite paddr pwdata prdata pready 3 addr, 32 data
//
// digit keys, error keys and keys seen after a halt finish in the accept cycle
// a key that closes an operand runs the 32-step serial alu, one bit per cycle, and its result
// is loaded into the result register from the post state
// synchronous active-low reset; operand_limit returns to 999, accumulator and operand to zero
// a key is taken only when the engine is idle and the result register is empty or draining;
// a stalled result register holds the engine in its post state
module keypad_calculator_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // key channel
    input  logic        i_key_valid,
    output logic        o_key_ready,
    input  logic [7:0]  i_key_code,
    // result channel
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [2:0]  o_status,
    output logic signed [31:0] o_value,
    // apb register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    kce_pkg::t_state              r_state;
    kce_pkg::t_state              n_state;

    logic [kce_pkg::OPND_W-1:0]   r_limit;
    logic [kce_pkg::ACC_W-1:0]    r_acc;
    kce_pkg::t_op                 r_op;
    logic [kce_pkg::OPND_W-1:0]   r_opnd;
    logic                         r_halted;
    logic [7:0]                   r_key;

    logic                         r_out_valid;
    kce_pkg::t_status             r_status;
    logic [kce_pkg::ACC_W-1:0]    r_value;

    logic                         w_slot;
    logic                         w_key_acc;
    logic                         w_digit;
    logic [3:0]                   w_dval;
    logic [kce_pkg::OPND_W+3:0]   w_ext;
    logic [kce_pkg::OPND_W-1:0]   w_next_opnd;
    logic                         w_closes;
    logic                         w_alu_start;
    logic                         w_post_load;
    kce_pkg::t_status             w_imm_status;
    kce_pkg::t_alu_req            w_req;
    kce_pkg::t_alu_rsp            w_rsp;

    // ---------------------------------------------------------------------------------------
    // apb register: one word, operand_limit in the low 14 bits
    // ---------------------------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= kce_pkg::LIMIT_RST;
        end else if (psel && penable && pwrite && pready && paddr[2] == kce_pkg::REG_LIMIT) begin
            r_limit <= pwdata[kce_pkg::OPND_W-1:0];
        end
    end

    assign prdata = (paddr[2] == kce_pkg::REG_LIMIT)
                    ? {{(32-kce_pkg::OPND_W){1'b0}}, r_limit} : 32'd0;

    // ---------------------------------------------------------------------------------------
    // key decode and operand entry
    // ---------------------------------------------------------------------------------------
    // result register is free when empty or its transfer happens this cycle
    assign w_slot    = !r_out_valid || i_res_ready;
    assign w_key_acc = i_key_valid && o_key_ready;

    assign w_digit = (i_key_code >= kce_pkg::KEY_0) && (i_key_code <= kce_pkg::KEY_9);
    assign w_dval  = 4'(i_key_code - kce_pkg::KEY_0);

    // operand*10 + digit as (x<<3)+(x<<1)+d, then saturate
    assign w_ext = {r_opnd, 3'b000} + {2'b00, r_opnd, 1'b0} + {14'd0, w_dval};
    assign w_next_opnd = (w_ext > {4'd0, kce_pkg::OPND_MAX}) ? kce_pkg::OPND_MAX
                                                            : w_ext[kce_pkg::OPND_W-1:0];

    // non-digit with a nonzero operand goes through the alu
    assign w_closes = !r_halted && !w_digit && (r_opnd != '0);

    // status of keys that finish in the accept cycle
    always_comb begin
        if (r_halted) begin
            w_imm_status = kce_pkg::STS_IGNORED;
        end else if (w_digit) begin
            w_imm_status = (w_next_opnd > r_limit) ? kce_pkg::STS_OVER : kce_pkg::STS_DIGIT;
        end else if (i_key_code == kce_pkg::KEY_EQ) begin
            w_imm_status = kce_pkg::STS_INCOMPLETE;
        end else begin
            w_imm_status = kce_pkg::STS_NO_NUMBER;
        end
    end

    // ---------------------------------------------------------------------------------------
    // control: next state
    // ---------------------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kce_pkg::ST_IDLE: begin
                if (w_key_acc && w_closes) begin
                    n_state = kce_pkg::ST_CALC;
                end
            end
            kce_pkg::ST_CALC: begin
                if (w_rsp.done) begin
                    n_state = kce_pkg::ST_POST;
                end
            end
            kce_pkg::ST_POST: begin
                if (w_slot) begin
                    n_state = kce_pkg::ST_IDLE;
                end
            end
            default: n_state = kce_pkg::ST_IDLE;
        endcase
    end

    // control: outputs
    always_comb begin
        o_key_ready = 1'b0;
        w_alu_start = 1'b0;
        w_post_load = 1'b0;
        unique case (r_state)
            kce_pkg::ST_IDLE: begin
                o_key_ready = w_slot;
                w_alu_start = w_key_acc && w_closes;
            end
            kce_pkg::ST_CALC: begin
            end
            kce_pkg::ST_POST: begin
                w_post_load = w_slot;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kce_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------------------------------------------------------------------------------
    // serial alu
    // ---------------------------------------------------------------------------------------
    assign w_req.start = w_alu_start;
    assign w_req.op    = r_op;
    assign w_req.acc   = r_acc;
    assign w_req.opnd  = r_opnd;

    kce_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // ---------------------------------------------------------------------------------------
    // calculator state
    // ---------------------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_op     <= kce_pkg::OP_NONE;
            r_opnd   <= '0;
            r_halted <= 1'b0;
        end else if (w_key_acc && !r_halted) begin
            if (w_digit) begin
                r_opnd <= w_next_opnd;
            end else if (r_opnd == '0) begin
                // empty or all-zero operand halts with an error
                r_halted <= 1'b1;
            end
        end else if (r_state == kce_pkg::ST_CALC && w_rsp.done) begin
            r_acc  <= w_rsp.result;
            r_opnd <= '0;
            unique case (r_key)
                kce_pkg::KEY_ADD: r_op <= kce_pkg::OP_ADD;
                kce_pkg::KEY_SUB: r_op <= kce_pkg::OP_SUB;
                kce_pkg::KEY_MUL: r_op <= kce_pkg::OP_MUL;
                kce_pkg::KEY_DIV: r_op <= kce_pkg::OP_DIV;
                kce_pkg::KEY_EQ:  r_halted <= 1'b1;
                default: begin
                    // other keys keep the pending operator
                end
            endcase
        end
    end

    // key held for the post-alu decode
    always_ff @(posedge i_clk) begin
        if (w_key_acc) begin
            r_key <= i_key_code;
        end
    end

    // ---------------------------------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((w_key_acc && !w_closes) || w_post_load) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_key_acc && !w_closes) begin
            r_status <= w_imm_status;
            r_value  <= r_acc;
        end else if (w_post_load) begin
            r_value <= r_acc;
            if (r_key == kce_pkg::KEY_ADD || r_key == kce_pkg::KEY_SUB
                || r_key == kce_pkg::KEY_MUL || r_key == kce_pkg::KEY_DIV) begin
                r_status <= kce_pkg::STS_OPER;
            end else if (r_key == kce_pkg::KEY_EQ) begin
                r_status <= kce_pkg::STS_RESULT;
            end else begin
                r_status <= kce_pkg::STS_OTHER;
            end
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_value     = r_value;

    // ---------------------------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------------------------
    // the alu finishes only while the engine waits on it
    a_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> r_state == kce_pkg::ST_CALC)
        else $error("alu done outside calc state");

    // a halt is sticky until reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt flag cleared without reset");

    // operand saturates at its maximum
    a_opnd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_opnd <= kce_pkg::OPND_MAX)
        else $error("operand above saturation value");

    // the closed operand is cleared once the alu result is taken
    a_post_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == kce_pkg::ST_POST |-> r_opnd == '0)
        else $error("operand not cleared after alu step");

    // no key is taken while an alu step runs
    a_no_key_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != kce_pkg::ST_IDLE |-> !o_key_ready)
        else $error("key ready while busy");

endmodule
